@@ hw/rtl/rcfd_pkg.sv @@
package rcfd_pkg;

    // widths fixed by the word fields
    localparam int RX_BYTE_W     = 8;
    localparam int STATUS_W      = 2;
    localparam int CH_ID_W       = 4;
    localparam int CH_VALUE_W    = 11;
    localparam int OUT_TDATA_W   = 24;
    localparam logic [RX_BYTE_W-1:0] SYNC_RESET = 8'hA2;

    // status codes, also the stored sync state (sync seen is output only)
    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 2'd0,
        ST_SYNC    = 2'd1,
        ST_COLLECT = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_READ,
        CS_EMIT
    } t_ctrl_state;

    // controller to datapath
    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic rd_issue;  // read the two bytes of the current channel
        logic ch_load;   // load the channel result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic completes; // the offered byte finishes a frame
        logic last_ch;   // current channel is the final one
        logic out_free;  // output register can take a result this cycle
    } t_dp_sts;

endpackage

@@ hw/rtl/rcfd_ctrl.sv @@
module rcfd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  rcfd_pkg::t_dp_sts i_sts,
    output logic              o_s_tready,
    output rcfd_pkg::t_dp_cmd o_cmd
);

    rcfd_pkg::t_ctrl_state r_state;
    rcfd_pkg::t_ctrl_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcfd_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_s_tready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.rd_issue = 1'b0;
        o_cmd.ch_load  = 1'b0;
        unique case (r_state)
            rcfd_pkg::CS_IDLE: begin
                o_s_tready   = i_sts.out_free;
                o_cmd.accept = i_s_tvalid && i_sts.out_free;
                if (o_cmd.accept && i_sts.completes) begin
                    n_state = rcfd_pkg::CS_READ;
                end
            end
            rcfd_pkg::CS_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = rcfd_pkg::CS_EMIT;
            end
            rcfd_pkg::CS_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.ch_load = 1'b1;
                    n_state = i_sts.last_ch ? rcfd_pkg::CS_IDLE : rcfd_pkg::CS_READ;
                end
            end
            default: begin
                n_state = rcfd_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/rcfd_datapath.sv @@
module rcfd_datapath #(
    parameter int FRAME_BYTES = 14,
    parameter int CHANNELS    = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [rcfd_pkg::RX_BYTE_W-1:0]       i_cfg_wr_data,
    input  logic [rcfd_pkg::RX_BYTE_W-1:0]       i_rx_byte,
    input  logic                                 i_m_tready,
    input  rcfd_pkg::t_dp_cmd                    i_cmd,
    output rcfd_pkg::t_dp_sts                    o_sts,
    output logic                                 o_m_tvalid,
    output logic                                 o_m_tlast,
    output logic                                 o_m_tuser,
    output logic [rcfd_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int BUF_DEPTH = (FRAME_BYTES > 2 * CHANNELS) ? FRAME_BYTES : 2 * CHANNELS;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(FRAME_BYTES);
    localparam int CH_W      = $clog2(CHANNELS);

    logic [rcfd_pkg::RX_BYTE_W-1:0] r_sync_value;
    rcfd_pkg::t_status              r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;
    logic [CH_W-1:0]                r_ch, n_ch;
    logic [rcfd_pkg::RX_BYTE_W-1:0] r_buf [BUF_DEPTH];
    logic [rcfd_pkg::RX_BYTE_W-1:0] r_hi, r_lo;

    logic                            r_valid, n_valid;
    rcfd_pkg::t_status               r_status, n_status;
    logic                            r_chv, n_chv;
    logic [rcfd_pkg::CH_ID_W-1:0]    r_id, n_id;
    logic [rcfd_pkg::CH_VALUE_W-1:0] r_value, n_value;
    logic                            r_last, n_last;

    logic             is_sync;
    logic             collect;
    logic [CNT_W:0]   count_inc;
    logic             at_end;
    logic             completes;
    logic             out_free;
    logic [ADDR_W-1:0] wr_addr, rd_addr_hi, rd_addr_lo;

    // byte classification
    assign is_sync   = (i_rx_byte == r_sync_value);
    assign collect   = !is_sync && (r_state == rcfd_pkg::ST_COLLECT);
    assign count_inc = {1'b0, r_count} + (CNT_W + 1)'(1);
    assign at_end    = (count_inc == (CNT_W + 1)'(FRAME_BYTES));
    assign completes = collect && at_end;
    assign out_free  = !r_valid || i_m_tready;

    assign o_sts.completes = completes;
    assign o_sts.last_ch   = (r_ch == CH_W'(CHANNELS - 1));
    assign o_sts.out_free  = out_free;

    // buffer addresses
    assign wr_addr    = ADDR_W'(r_count);
    assign rd_addr_hi = ADDR_W'({r_ch, 1'b0});
    assign rd_addr_lo = ADDR_W'({r_ch, 1'b1});

    // sync register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= rcfd_pkg::SYNC_RESET;
        end else if (i_cfg_wr_en) begin
            r_sync_value <= i_cfg_wr_data;
        end
    end

    // frame state and byte count
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        if (i_cmd.accept) begin
            if (is_sync) begin
                n_state = rcfd_pkg::ST_COLLECT;
                n_count = '0;
            end else if (collect) begin
                if (at_end) begin
                    n_state = rcfd_pkg::ST_DONE;
                    n_count = '0;
                end else begin
                    n_count = count_inc[CNT_W-1:0];
                end
            end
        end
    end

    // channel counter
    always_comb begin
        n_ch = r_ch;
        if (i_cmd.accept && completes) begin
            n_ch = '0;
        end else if (i_cmd.ch_load) begin
            n_ch = r_ch + CH_W'(1);
        end
    end

    // output register next value
    always_comb begin
        n_valid  = r_valid;
        n_status = r_status;
        n_chv    = r_chv;
        n_id     = r_id;
        n_value  = r_value;
        n_last   = r_last;
        priority if (i_cmd.accept && !completes) begin
            n_valid  = 1'b1;
            n_status = is_sync ? rcfd_pkg::ST_SYNC
                     : (collect ? rcfd_pkg::ST_COLLECT : r_state);
            n_chv    = 1'b0;
            n_id     = '0;
            n_value  = '0;
            n_last   = 1'b1;
        end else if (i_cmd.ch_load) begin
            n_valid  = 1'b1;
            n_status = rcfd_pkg::ST_DONE;
            n_chv    = 1'b1;
            n_id     = r_hi[6:3];
            n_value  = {r_hi[2:0], r_lo};
            n_last   = o_sts.last_ch;
        end else if (i_m_tready) begin
            n_valid  = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcfd_pkg::ST_IDLE;
            r_count <= '0;
            r_ch    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ch    <= n_ch;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_chv    <= n_chv;
        r_id     <= n_id;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    // frame buffer, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && collect) begin
            r_buf[wr_addr] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_hi <= r_buf[rd_addr_hi];
            r_lo <= r_buf[rd_addr_lo];
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_chv;
    assign o_m_tdata  = {7'd0, r_value, r_id, r_status};

endmodule

@@ hw/rtl/rc_receiver_frame_decoder_top.sv @@
// status bytes: result in the output register in the cycle after the byte is taken,
// and a new byte can be taken every cycle while the output side keeps up
// completing byte: CHANNELS results, each by a buffer read, then an output load that
// waits for a free output register; no byte is taken until the last result is loaded
// reset (synchronous, active low): not synced, count cleared, sync value 0xA2,
// output empty; the frame buffer is not cleared
module rc_receiver_frame_decoder_top #(
    parameter int FRAME_BYTES = 14,
    parameter int CHANNELS    = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rcfd_pkg::RX_BYTE_W-1:0]    i_cfg_wr_data,  // sync_value
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rcfd_pkg::RX_BYTE_W-1:0]    i_s_tdata,      // [7:0] rx_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [1:0] status, [5:2] channel_id, [16:6] channel_value, [23:17] zero
    output logic [rcfd_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tuser,      // [0] channel_valid
    output logic                              o_m_tlast       // last
);

    rcfd_pkg::t_dp_cmd cmd;
    rcfd_pkg::t_dp_sts sts;

    // sequencer
    rcfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // buffer, counters and output register
    rcfd_datapath #(
        .FRAME_BYTES (FRAME_BYTES),
        .CHANNELS    (CHANNELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_byte     (i_s_tdata),
        .i_m_tready    (i_m_tready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tlast     (o_m_tlast),
        .o_m_tuser     (o_m_tuser),
        .o_m_tdata     (o_m_tdata)
    );

    // no byte taken while channel results are being read out
    a_no_accept_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_issue |-> !o_s_tready)
        else $error("input ready during channel read");

    // a completing byte starts the channel readout next cycle
    a_complete_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && sts.completes) |=> cmd.rd_issue)
        else $error("frame end did not start channel readout");

    // channel results only ever carry the frame complete status
    a_channel_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[1:0] == rcfd_pkg::ST_DONE))
        else $error("channel result with wrong status");

    // a status result is always the final one for its byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> o_m_tlast)
        else $error("status result without last");

endmodule
